@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL of the colour blend and fade block.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held
`define ASSERT_IMPL(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is held
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/core/rbf_pkg.sv @@
// Types and constants of the rgb555 blend and fade block.
// Depends on nothing; imported by rgb555_blend_and_fade_top.
`timescale 1ns / 1ps

package rbf_pkg;

  typedef logic [4:0]  chan_t;
  typedef logic [15:0] color_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_BLEND_MODE   = 2'd0,
    REG_BLEND_WEIGHT = 2'd1,
    REG_FADE_LEVEL   = 2'd2,
    REG_UNUSED       = 2'd3
  } cfg_reg_t;

  localparam color_t WHITE_COLOR = 16'h7FFF;
  localparam color_t BLACK_COLOR = 16'h0000;
  localparam chan_t  CHAN_MAX    = 5'd31;
  localparam int     NUM_CHAN    = 3;

endpackage

@@ rtl/core/rgb555_blend_and_fade_top.sv @@
// Top level of the rgb555 blend and fade block: five-stage pipeline.
// Depends on rbf_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// One palette colour per transaction, one transaction per clock. A colour
// accepted on start leaves the last stage with out_valid high for
// one cycle; busy never rises, so start may be held high for a stream. The
// five register stages are: operand prepare, blend multiply, blend add and
// pass select, fade multiply, fade finish. The receiver cannot stall the
// output. Configuration is written on cfg_we with cfg_index 0 for the blend
// mode, 1 for the blend weight and 2 for the signed fade level; index 3 is
// ignored. Write it only when no transaction is in flight.
module rgb555_blend_and_fade_top
  import rbf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_source_color,
  input  logic [15:0] in_target_color,
  input  logic        in_last_entry,
  output logic        out_valid,
  output logic [15:0] out_result_color,
  output logic        out_last_entry_out,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data
);

  // Configuration registers
  logic              mode_r;
  logic [5:0]        weight_r;
  logic signed [6:0] fade_r;

  // Valid bits, one per stage
  logic v1_r, v2_r, v3_r, v4_r, v5_r;

  // Stage 1: channel base and signed difference
  chan_t             base1_r [NUM_CHAN];
  logic signed [5:0] diff1_r [NUM_CHAN];
  color_t            src1_r, tgt1_r;
  logic              last1_r;

  // Stage 2: weighted difference
  chan_t              base2_r [NUM_CHAN];
  logic signed [12:0] prod2_r [NUM_CHAN];
  color_t             src2_r, tgt2_r;
  logic               last2_r;

  // Stage 3: stage-one colour
  color_t col3_r;
  logic   last3_r;

  // Stage 4: fade product
  logic [9:0] prod4_r [NUM_CHAN];
  color_t     col4_r;
  logic       last4_r;

  // Stage 5: output
  color_t res5_r;
  logic   last5_r;

  // Combinational next values
  chan_t              base1_nxt [NUM_CHAN];
  logic signed [5:0]  diff1_nxt [NUM_CHAN];
  logic signed [12:0] prod2_nxt [NUM_CHAN];
  color_t             col3_nxt;
  logic [9:0]         prod4_nxt [NUM_CHAN];
  color_t             res5_nxt;

  logic              fade_pos;
  logic [6:0]        fade_abs;
  chan_t             fade_k;
  logic              fade_white, fade_black, fade_zero;

  assign busy = 1'b0;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 1'b0;
      weight_r <= '0;
      fade_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BLEND_MODE:   mode_r   <= cfg_data[0];
        REG_BLEND_WEIGHT: weight_r <= cfg_data[5:0];
        REG_FADE_LEVEL:   fade_r   <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // Stage 1: target minus source, or 31 minus twice the source
  always_comb begin
    for (int j = 0; j < NUM_CHAN; j++) begin
      base1_nxt[j] = in_source_color[5*j +: 5];
      if (mode_r) begin
        diff1_nxt[j] = $signed({1'b0, CHAN_MAX}) - $signed({base1_nxt[j], 1'b0});
      end else begin
        diff1_nxt[j] = $signed({1'b0, in_target_color[5*j +: 5]})
                     - $signed({1'b0, base1_nxt[j]});
      end
    end
  end

  // Stage 2: multiply by the weight, both operands at full product width
  always_comb begin
    for (int j = 0; j < NUM_CHAN; j++) begin
      prod2_nxt[j] = $signed({7'b0, weight_r}) * 13'(diff1_r[j]);
    end
  end

  // Stage 3: add floor of the product over 32, or pass a colour through
  always_comb begin
    logic signed [12:0] q;
    col3_nxt = '0;
    for (int j = 0; j < NUM_CHAN; j++) begin
      q = prod2_r[j] >>> 5;
      col3_nxt[5*j +: 5] = base2_r[j] + q[4:0];
    end
    if (!mode_r && weight_r == 6'd0) begin
      col3_nxt = src2_r;
    end else if (!mode_r && weight_r > 6'd31) begin
      col3_nxt = tgt2_r;
    end
  end

  // Fade decode
  always_comb begin
    fade_pos   = !fade_r[6];
    fade_abs   = fade_r[6] ? 7'(-fade_r) : fade_r;
    fade_k     = CHAN_MAX - fade_abs[4:0];
    fade_zero  = fade_r == 7'sd0;
    fade_white = fade_r > 7'sd31;
    fade_black = fade_r < -7'sd31;
  end

  // Stage 4: multiply by the fade factor
  always_comb begin
    chan_t c;
    for (int j = 0; j < NUM_CHAN; j++) begin
      c = col3_r[5*j +: 5];
      prod4_nxt[j] = fade_k * (fade_pos ? chan_t'(CHAN_MAX - c) : c);
    end
  end

  // Stage 5: finish the fade, force white or black, or pass the colour through
  always_comb begin
    res5_nxt = '0;
    for (int j = 0; j < NUM_CHAN; j++) begin
      res5_nxt[5*j +: 5] = fade_pos ? chan_t'(CHAN_MAX - prod4_r[j][9:5])
                                    : prod4_r[j][9:5];
    end
    if (fade_zero) begin
      res5_nxt = col4_r;
    end else if (fade_white) begin
      res5_nxt = WHITE_COLOR;
    end else if (fade_black) begin
      res5_nxt = BLACK_COLOR;
    end
  end

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  // Advance the payload
  always_ff @(posedge clk) begin
    base1_r <= base1_nxt;
    diff1_r <= diff1_nxt;
    src1_r  <= in_source_color;
    tgt1_r  <= in_target_color;
    last1_r <= in_last_entry;

    base2_r <= base1_r;
    prod2_r <= prod2_nxt;
    src2_r  <= src1_r;
    tgt2_r  <= tgt1_r;
    last2_r <= last1_r;

    col3_r  <= col3_nxt;
    last3_r <= last2_r;

    prod4_r <= prod4_nxt;
    col4_r  <= col3_r;
    last4_r <= last3_r;

    res5_r  <= res5_nxt;
    last5_r <= last4_r;
  end

  assign out_valid          = v5_r;
  assign out_result_color   = res5_r;
  assign out_last_entry_out = last5_r;

  // Checks
  `ASSERT_NEXT(a_valid_flow, clk, rst_n, v4_r, out_valid)
  `ASSERT_IMPL(a_fade_white, clk, rst_n, out_valid && fade_white, out_result_color == WHITE_COLOR)
  `ASSERT_IMPL(a_fade_black, clk, rst_n, out_valid && fade_black, out_result_color == BLACK_COLOR)
  `ASSERT_IMPL(a_plain_pass, clk, rst_n, out_valid && fade_zero && !mode_r && weight_r == 6'd0, out_result_color == $past(in_source_color, 5))

endmodule
